[design/srlru_pkg.sv]
// ----------------------------------------------------------------------------
// srlru_pkg
// Shared types and constants of the scan-resistant LRU replacement engine.
// ----------------------------------------------------------------------------
package srlru_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVICT  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  localparam logic [1:0] WHERE_NONE = 2'd0;
  localparam logic [1:0] WHERE_R    = 2'd1;
  localparam logic [1:0] WHERE_SR   = 2'd2;
  localparam logic [1:0] WHERE_HIST = 2'd3;

  localparam logic LIST_R  = 1'b0;
  localparam logic LIST_SR = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_META      = 2'd1;

  localparam int TARGET_W = 16;
  localparam int META_W   = 2;
  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 32;

  localparam logic [TARGET_W-1:0] CAP_RESET  = 16'd256;
  localparam logic [TARGET_W-1:0] HALF_RESET = 16'd128;

  // per-sweep result flags of a table scan
  typedef struct packed {
    logic match;
    logic free;
    logic lru_r;
    logic lru_sr;
  } scan_res_t;

endpackage

[design/srlru_ram.sv]
// ----------------------------------------------------------------------------
// srlru_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module srlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/srlru_div.sv]
// ----------------------------------------------------------------------------
// srlru_div
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module srlru_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int CW = $clog2(W + 1);

  logic         active_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0] dvd_q, dvs_q;
  logic [W:0]   rem_q;
  logic [W:0]   rem_sh;
  logic         take;

  assign rem_sh = {rem_q[W-1:0], dvd_q[W-1]};
  assign take   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          dvd_q  <= '0;
          done_q <= 1'b1;
        end else begin
          dvd_q    <= dividend_i;
          dvs_q    <= divisor_i;
          rem_q    <= '0;
          cnt_q    <= CW'(W);
          active_q <= 1'b1;
        end
      end else if (active_q) begin
        rem_q <= take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        dvd_q <= {dvd_q[W-2:0], take};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

[design/srlru_scan.sv]
// ----------------------------------------------------------------------------
// srlru_scan
// Table sweep unit: one entry per cycle, finds key match, first free slot
// and the oldest entry of each list.
// ----------------------------------------------------------------------------
module srlru_scan #(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 32,
  parameter int STAMP_W  = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [DEPTH-1:0]      valid_i,
  input  logic [KEY_BITS-1:0]   rd_key_i,
  input  logic                  rd_list_i,
  input  logic [STAMP_W-1:0]    rd_stamp_i,
  output logic [AW-1:0]         rd_addr_o,
  output logic                  active_o,
  output logic                  done_o,
  output srlru_pkg::scan_res_t  res_o,
  output logic [AW-1:0]         match_idx_o,
  output logic [AW-1:0]         free_idx_o,
  output logic [AW-1:0]         lru_r_idx_o,
  output logic [AW-1:0]         lru_sr_idx_o
);

  import srlru_pkg::*;

  logic [AW:0]        cnt_q;
  logic               active_q, pvld_q, done_q;
  logic [AW-1:0]      pidx_q;
  scan_res_t          res_q;
  logic [AW-1:0]      match_q, free_q, lru_r_q, lru_sr_q;
  logic [STAMP_W-1:0] best_r_q, best_sr_q;
  logic               e_vld;

  assign e_vld = valid_i[pidx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      pvld_q   <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q    <= '0;
        active_q <= 1'b1;
        pvld_q   <= 1'b0;
        res_q    <= '0;
      end else if (active_q) begin
        // each address is issued in the cycle before its entry is compared
        if (cnt_q < (AW+1)'(DEPTH)) begin
          pidx_q <= cnt_q[AW-1:0];
          pvld_q <= 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          pvld_q <= 1'b0;
        end
        if (pvld_q) begin
          if (e_vld && rd_key_i == key_i && !res_q.match) begin
            res_q.match <= 1'b1;
            match_q     <= pidx_q;
          end
          if (!e_vld && !res_q.free) begin
            res_q.free <= 1'b1;
            free_q     <= pidx_q;
          end
          if (e_vld && rd_list_i == LIST_R && (!res_q.lru_r || rd_stamp_i < best_r_q)) begin
            res_q.lru_r <= 1'b1;
            lru_r_q     <= pidx_q;
            best_r_q    <= rd_stamp_i;
          end
          if (e_vld && rd_list_i == LIST_SR &&
              (!res_q.lru_sr || rd_stamp_i < best_sr_q)) begin
            res_q.lru_sr <= 1'b1;
            lru_sr_q     <= pidx_q;
            best_sr_q    <= rd_stamp_i;
          end
          if (pidx_q == AW'(DEPTH - 1)) begin
            active_q <= 1'b0;
            pvld_q   <= 1'b0;
            done_q   <= 1'b1;
          end
        end
      end
    end
  end

  assign rd_addr_o    = cnt_q[AW-1:0];
  assign active_o     = active_q;
  assign done_o       = done_q;
  assign res_o        = res_q;
  assign match_idx_o  = match_q;
  assign free_idx_o   = free_q;
  assign lru_r_idx_o  = lru_r_q;
  assign lru_sr_idx_o = lru_sr_q;

endmodule

[design/sr_lru_cache_replacement_top.sv]
// ----------------------------------------------------------------------------
// sr_lru_cache_replacement_top
// Scan-resistant LRU replacement engine with R, SR and history lists.
// ----------------------------------------------------------------------------
// One request word is worked on at a time; in_ready_o is high only while the
// sequencer is idle. The cost is set by sweeps over the two entry tables, with
// one memory read per cycle. A get costs one cache sweep, one history sweep on a
// miss, one more sweep for each entry demoted, spilled or trimmed (a spill adds a
// history sweep), and a divider run when the SR target is recomputed. The
// result word sits in an output register, so a finished word may wait while the
// next request is accepted. Configuration writes are taken at any time but must
// be issued only while idle.
module sr_lru_cache_replacement_top #(
  parameter int CACHE_ENTRIES   = 256,
  parameter int HISTORY_ENTRIES = 256,
  parameter int KEY_BITS        = 32,
  parameter int SIZE_BITS       = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srlru_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srlru_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [KEY_BITS-1:0]                object_key_i,
  input  logic [SIZE_BITS-1:0]               object_size_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [1:0]                         hit_where_o,
  output logic                               admitted_o,
  output logic                               removed_o,
  output logic [KEY_BITS-1:0]                evicted_key_o,
  output logic [srlru_pkg::TARGET_W-1:0]     sr_target_now_o
);

  import srlru_pkg::*;

  localparam int CAW      = $clog2(CACHE_ENTRIES);
  localparam int HAW      = $clog2(HISTORY_ENTRIES);
  localparam int WEIGHT_W = SIZE_BITS + 1;
  localparam int OCC_W    = CAW + WEIGHT_W;
  localparam int HOCC_W   = HAW + WEIGHT_W;
  localparam int MAX_A    = (OCC_W > HOCC_W) ? OCC_W : HOCC_W;
  localparam int MAX_B    = (MAX_A > CNT_W) ? MAX_A : CNT_W;
  localparam int WIDE_W   = MAX_B + 2;
  localparam int C_LIST   = KEY_BITS + WEIGHT_W;
  localparam int C_W      = C_LIST + 3 + STAMP_W;
  localparam int H_NEW    = KEY_BITS + WEIGHT_W;
  localparam int H_W      = H_NEW + 1 + STAMP_W;

  typedef enum logic [4:0] {
    S_IDLE, S_CSCAN, S_HSCAN, S_CRD, S_CRD2, S_HRD, S_HRD2, S_DISPATCH,
    S_EV_KEY, S_G_HIT, S_DLOOP, S_DL_SEL, S_DEMOTE, S_G_SR_POST, S_DIV_WAIT,
    S_SHRINK, S_G_MISS, S_G_H_DROP, S_G_H_PLACE, S_GROW, S_SPILL, S_SPILL_SEL,
    S_C2H_BEGIN, S_C2H_SLOT, S_C2H_DROP, S_C2H_WRITE, S_TRIM, S_TRIM_SEL,
    S_TRIM_DROP, S_DONE
  } state_e;

  state_e state_q, ret_q, dl_ret_q, c2h_ret_q;
  logic   dl_plus_q;

  opcode_e             op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [WEIGHT_W-1:0] w_q;

  logic                res_hit_q, res_adm_q, res_rem_q;
  logic [1:0]          res_where_q;
  logic [KEY_BITS-1:0] res_ek_q;

  logic                out_valid_q, out_hit_q, out_adm_q, out_rem_q;
  logic [1:0]          out_where_q;
  logic [KEY_BITS-1:0] out_ek_q;
  logic [TARGET_W-1:0] out_sr_q;

  logic [TARGET_W-1:0] tc_q, sr_q, r_q;
  logic [META_W-1:0]   meta_q;
  logic [CNT_W-1:0]    new_cnt_q, dem_cnt_q, q_q, div_a_q, div_b_q;
  logic [STAMP_W-1:0]  stamp_q, stamp_n;
  logic [OCC_W-1:0]    occ_r_q, occ_sr_q;
  logic [HOCC_W-1:0]   occ_h_q;

  logic [CACHE_ENTRIES-1:0]   cvalid_q;
  logic [HISTORY_ENTRIES-1:0] hvalid_q;

  logic [CAW-1:0]      c_rd_idx_q, ent_idx_q;
  logic [HAW-1:0]      h_rd_idx_q, hslot_q;
  logic [KEY_BITS-1:0] ent_key_q;
  logic [WEIGHT_W-1:0] ent_w_q, hw_q;
  logic                ent_list_q, ent_new_q, ent_dem_q, hnew_q, was_dem_q, was_new_q;
  logic                cstart_q, hstart_q, div_start_q;

  // memory and scan wiring
  logic           c_we, h_we;
  logic [CAW-1:0] c_waddr, c_raddr, cs_addr, c_match, c_free, c_lru_r, c_lru_sr;
  logic [HAW-1:0] h_waddr, h_raddr, hs_addr, h_match, h_free, h_lru, h_lru_sr;
  logic [C_W-1:0] c_wdata, c_rdata;
  logic [H_W-1:0] h_wdata, h_rdata;
  logic           cs_active, cs_done, hs_active, hs_done, div_done;
  scan_res_t      cres, hres;
  logic [CNT_W-1:0] div_q;

  logic fits, admit, place_sr;
  logic [WIDE_W-1:0] v_shrink, v_grow, occ_sum, occ_cap, q_one, ns, q_p1;
  logic [TARGET_W-1:0] sr_set, r_set;

  function automatic logic [TARGET_W-1:0] clamp_sr(input logic [WIDE_W-1:0] v,
                                                   input logic [TARGET_W-1:0] tc);
    logic [TARGET_W-1:0] s;
    if (v > WIDE_W'(tc)) s = tc;
    else                 s = v[TARGET_W-1:0];
    if (s == '0) s = TARGET_W'(1);
    return s;
  endfunction

  assign stamp_n = stamp_q + 1'b1;
  assign c_raddr = cs_active ? cs_addr : c_rd_idx_q;
  assign h_raddr = hs_active ? hs_addr : h_rd_idx_q;

  srlru_ram #(.WIDTH(C_W), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  srlru_ram #(.WIDTH(H_W), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  srlru_scan #(.DEPTH(CACHE_ENTRIES), .KEY_BITS(KEY_BITS), .STAMP_W(STAMP_W)) u_cscan (
    .clk_i, .rst_ni, .start_i(cstart_q), .key_i(key_q), .valid_i(cvalid_q),
    .rd_key_i(c_rdata[KEY_BITS-1:0]), .rd_list_i(c_rdata[C_LIST]),
    .rd_stamp_i(c_rdata[C_LIST+3 +: STAMP_W]), .rd_addr_o(cs_addr),
    .active_o(cs_active), .done_o(cs_done), .res_o(cres), .match_idx_o(c_match),
    .free_idx_o(c_free), .lru_r_idx_o(c_lru_r), .lru_sr_idx_o(c_lru_sr)
  );

  // history entries all carry the R tag, so lru_r is the history LRU
  srlru_scan #(.DEPTH(HISTORY_ENTRIES), .KEY_BITS(KEY_BITS), .STAMP_W(STAMP_W)) u_hscan (
    .clk_i, .rst_ni, .start_i(hstart_q), .key_i(key_q), .valid_i(hvalid_q),
    .rd_key_i(h_rdata[KEY_BITS-1:0]), .rd_list_i(LIST_R),
    .rd_stamp_i(h_rdata[H_NEW+1 +: STAMP_W]), .rd_addr_o(hs_addr),
    .active_o(hs_active), .done_o(hs_done), .res_o(hres), .match_idx_o(h_match),
    .free_idx_o(h_free), .lru_r_idx_o(h_lru), .lru_sr_idx_o(h_lru_sr)
  );

  srlru_div #(.W(CNT_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .dividend_i(div_a_q), .divisor_i(div_b_q),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    fits     = hres.match ? (WIDE_W'(w_q) <= WIDE_W'(r_q)) : (WIDE_W'(w_q) <= WIDE_W'(sr_q));
    admit    = fits && cres.free;
    place_sr = admit && !hres.match;

    q_p1     = WIDE_W'(q_q) + 1'b1;
    v_shrink = (WIDE_W'(sr_q) > q_p1) ? (WIDE_W'(sr_q) - q_p1) : WIDE_W'(1);
    occ_sum  = WIDE_W'(occ_r_q) + WIDE_W'(occ_sr_q);
    occ_cap  = (occ_sum == '0) ? '0 : occ_sum - 1'b1;
    q_one    = (q_q == '0) ? WIDE_W'(1) : WIDE_W'(q_q);
    ns       = WIDE_W'(sr_q) + q_one;
    v_grow   = (ns < occ_cap) ? ns : occ_cap;
    sr_set   = clamp_sr((state_q == S_SHRINK) ? v_shrink : v_grow, tc_q);
    r_set    = (tc_q >= sr_set) ? (tc_q - sr_set) : '0;
  end

  always_comb begin
    c_we    = 1'b0;
    c_waddr = ent_idx_q;
    c_wdata = {stamp_n, ent_dem_q, ent_new_q, ent_list_q, ent_w_q, ent_key_q};
    h_we    = 1'b0;
    h_waddr = hslot_q;
    h_wdata = {stamp_n, ent_new_q, ent_w_q, ent_key_q};
    unique case (state_q)
      S_G_HIT: begin
        c_we = 1'b1;
        if (ent_list_q != LIST_R) begin
          c_wdata = {stamp_n, 1'b0, 1'b0, LIST_R, ent_w_q, ent_key_q};
        end
      end
      S_DEMOTE: begin
        c_we    = 1'b1;
        c_wdata = {stamp_n, 1'b1, 1'b0, LIST_SR, ent_w_q, ent_key_q};
      end
      S_G_MISS: begin
        if (place_sr) begin
          c_we    = 1'b1;
          c_waddr = c_free;
          c_wdata = {stamp_n, 1'b0, 1'b1, LIST_SR, w_q, key_q};
        end
      end
      S_G_H_PLACE: begin
        c_we    = 1'b1;
        c_waddr = c_free;
        c_wdata = {stamp_n, 1'b0, 1'b0, LIST_R, w_q, key_q};
      end
      S_C2H_WRITE: h_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      dl_ret_q    <= S_IDLE;
      c2h_ret_q   <= S_IDLE;
      dl_plus_q   <= 1'b0;
      out_valid_q <= 1'b0;
      tc_q        <= CAP_RESET;
      sr_q        <= HALF_RESET;
      r_q         <= HALF_RESET;
      meta_q      <= '0;
      new_cnt_q   <= '0;
      dem_cnt_q   <= '0;
      stamp_q     <= '0;
      occ_r_q     <= '0;
      occ_sr_q    <= '0;
      occ_h_q     <= '0;
      cvalid_q    <= '0;
      hvalid_q    <= '0;
      cstart_q    <= 1'b0;
      hstart_q    <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      cstart_q    <= 1'b0;
      hstart_q    <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_TOTAL_CAP: begin
            tc_q <= cfg_data_i;
            r_q  <= cfg_data_i >> 1;
            sr_q <= ((cfg_data_i >> 1) == '0) ? TARGET_W'(1) : (cfg_data_i >> 1);
          end
          CFG_META: meta_q <= cfg_data_i[META_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q        <= opcode_e'(opcode_i);
            key_q       <= object_key_i;
            w_q         <= WEIGHT_W'(object_size_i) + WEIGHT_W'(meta_q);
            res_hit_q   <= 1'b0;
            res_where_q <= WHERE_NONE;
            res_adm_q   <= 1'b0;
            res_rem_q   <= 1'b0;
            res_ek_q    <= '0;
            if (opcode_e'(opcode_i) == OP_NOP) begin
              state_q <= S_DONE;
            end else begin
              cstart_q <= 1'b1;
              ret_q    <= S_DISPATCH;
              state_q  <= S_CSCAN;
            end
          end
        end
        S_CSCAN: if (cs_done) state_q <= ret_q;
        S_HSCAN: if (hs_done) state_q <= ret_q;
        S_CRD:   state_q <= S_CRD2;
        S_CRD2: begin
          ent_idx_q  <= c_rd_idx_q;
          ent_key_q  <= c_rdata[KEY_BITS-1:0];
          ent_w_q    <= c_rdata[KEY_BITS +: WEIGHT_W];
          ent_list_q <= c_rdata[C_LIST];
          ent_new_q  <= c_rdata[C_LIST+1];
          ent_dem_q  <= c_rdata[C_LIST+2];
          state_q    <= ret_q;
        end
        S_HRD:   state_q <= S_HRD2;
        S_HRD2: begin
          hw_q    <= h_rdata[KEY_BITS +: WEIGHT_W];
          hnew_q  <= h_rdata[H_NEW];
          state_q <= ret_q;
        end
        S_DISPATCH: begin
          unique case (op_q)
            OP_GET: begin
              if (cres.match) begin
                res_hit_q  <= 1'b1;
                c_rd_idx_q <= c_match;
                ret_q      <= S_G_HIT;
                state_q    <= S_CRD;
              end else begin
                hstart_q <= 1'b1;
                ret_q    <= S_G_MISS;
                state_q  <= S_HSCAN;
              end
            end
            OP_REMOVE: begin
              if (cres.match) begin
                res_rem_q  <= 1'b1;
                c_rd_idx_q <= c_match;
                c2h_ret_q  <= S_TRIM;
                ret_q      <= S_C2H_BEGIN;
                state_q    <= S_CRD;
              end else begin
                state_q <= S_DONE;
              end
            end
            OP_EVICT: begin
              if (cres.lru_sr || cres.lru_r) begin
                res_rem_q  <= 1'b1;
                c_rd_idx_q <= cres.lru_sr ? c_lru_sr : c_lru_r;
                c2h_ret_q  <= S_TRIM;
                ret_q      <= S_EV_KEY;
                state_q    <= S_CRD;
              end else begin
                state_q <= S_DONE;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_EV_KEY: begin
          res_ek_q <= ent_key_q;
          state_q  <= S_C2H_BEGIN;
        end
        S_G_HIT: begin
          stamp_q <= stamp_n;
          if (ent_list_q == LIST_R) begin
            res_where_q <= WHERE_R;
            state_q     <= S_DONE;
          end else begin
            res_where_q <= WHERE_SR;
            was_dem_q   <= ent_dem_q;
            occ_sr_q    <= occ_sr_q - OCC_W'(ent_w_q);
            occ_r_q     <= occ_r_q + OCC_W'(ent_w_q);
            dl_plus_q   <= 1'b0;
            dl_ret_q    <= S_G_SR_POST;
            state_q     <= S_DLOOP;
          end
        end
        // demote R entries until R fits its target
        S_DLOOP: begin
          if ((WIDE_W'(occ_r_q) + (dl_plus_q ? WIDE_W'(w_q) : '0)) > WIDE_W'(r_q)) begin
            cstart_q <= 1'b1;
            ret_q    <= S_DL_SEL;
            state_q  <= S_CSCAN;
          end else begin
            state_q <= dl_ret_q;
          end
        end
        S_DL_SEL: begin
          if (cres.lru_r) begin
            c_rd_idx_q <= c_lru_r;
            ret_q      <= S_DEMOTE;
            state_q    <= S_CRD;
          end else begin
            state_q <= dl_ret_q;
          end
        end
        S_DEMOTE: begin
          stamp_q  <= stamp_n;
          occ_r_q  <= occ_r_q - OCC_W'(ent_w_q);
          occ_sr_q <= occ_sr_q + OCC_W'(ent_w_q);
          if (!ent_dem_q && dem_cnt_q != '1) dem_cnt_q <= dem_cnt_q + 1'b1;
          state_q  <= S_DLOOP;
        end
        S_G_SR_POST: begin
          if (was_dem_q) begin
            div_a_q     <= new_cnt_q;
            div_b_q     <= dem_cnt_q;
            div_start_q <= 1'b1;
            ret_q       <= S_SHRINK;
            state_q     <= S_DIV_WAIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            q_q     <= div_q;
            state_q <= ret_q;
          end
        end
        S_SHRINK: begin
          sr_q <= sr_set;
          r_q  <= r_set;
          if (dem_cnt_q != '0) dem_cnt_q <= dem_cnt_q - 1'b1;
          state_q <= S_DONE;
        end
        S_G_MISS: begin
          if (hres.match) res_where_q <= WHERE_HIST;
          if (admit) begin
            res_adm_q <= 1'b1;
            if (hres.match) begin
              h_rd_idx_q <= h_match;
              ret_q      <= S_G_H_DROP;
              state_q    <= S_HRD;
            end else begin
              stamp_q          <= stamp_n;
              cvalid_q[c_free] <= 1'b1;
              occ_sr_q         <= occ_sr_q + OCC_W'(w_q);
              state_q          <= S_SPILL;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_G_H_DROP: begin
          was_new_q            <= hnew_q;
          hvalid_q[h_rd_idx_q] <= 1'b0;
          occ_h_q              <= occ_h_q - HOCC_W'(hw_q);
          dl_plus_q            <= 1'b1;
          dl_ret_q             <= S_G_H_PLACE;
          state_q              <= S_DLOOP;
        end
        S_G_H_PLACE: begin
          stamp_q          <= stamp_n;
          cvalid_q[c_free] <= 1'b1;
          occ_r_q          <= occ_r_q + OCC_W'(w_q);
          if (was_new_q) begin
            div_a_q     <= dem_cnt_q;
            div_b_q     <= new_cnt_q;
            div_start_q <= 1'b1;
            ret_q       <= S_GROW;
            state_q     <= S_DIV_WAIT;
          end else begin
            state_q <= S_SPILL;
          end
        end
        S_GROW: begin
          sr_q    <= sr_set;
          r_q     <= r_set;
          state_q <= S_SPILL;
        end
        // SR overflow goes to history
        S_SPILL: begin
          if (WIDE_W'(occ_sr_q) > WIDE_W'(sr_q)) begin
            cstart_q <= 1'b1;
            ret_q    <= S_SPILL_SEL;
            state_q  <= S_CSCAN;
          end else begin
            state_q <= S_TRIM;
          end
        end
        S_SPILL_SEL: begin
          if (cres.lru_sr) begin
            c_rd_idx_q <= c_lru_sr;
            c2h_ret_q  <= S_SPILL;
            ret_q      <= S_C2H_BEGIN;
            state_q    <= S_CRD;
          end else begin
            state_q <= S_TRIM;
          end
        end
        S_C2H_BEGIN: begin
          hstart_q <= 1'b1;
          ret_q    <= S_C2H_SLOT;
          state_q  <= S_HSCAN;
        end
        S_C2H_SLOT: begin
          if (hres.free) begin
            hslot_q <= h_free;
            state_q <= S_C2H_WRITE;
          end else begin
            hslot_q    <= h_lru;
            h_rd_idx_q <= h_lru;
            ret_q      <= S_C2H_DROP;
            state_q    <= S_HRD;
          end
        end
        S_C2H_DROP: begin
          occ_h_q <= occ_h_q - HOCC_W'(hw_q);
          state_q <= S_C2H_WRITE;
        end
        S_C2H_WRITE: begin
          stamp_q             <= stamp_n;
          hvalid_q[hslot_q]   <= 1'b1;
          occ_h_q             <= occ_h_q + HOCC_W'(ent_w_q);
          if (ent_new_q && new_cnt_q != '1) new_cnt_q <= new_cnt_q + 1'b1;
          if (ent_dem_q && dem_cnt_q != '0) dem_cnt_q <= dem_cnt_q - 1'b1;
          if (ent_list_q == LIST_R) occ_r_q <= occ_r_q - OCC_W'(ent_w_q);
          else                      occ_sr_q <= occ_sr_q - OCC_W'(ent_w_q);
          cvalid_q[ent_idx_q] <= 1'b0;
          state_q             <= c2h_ret_q;
        end
        S_TRIM: begin
          if (WIDE_W'(occ_h_q) >= WIDE_W'(tc_q)) begin
            hstart_q <= 1'b1;
            ret_q    <= S_TRIM_SEL;
            state_q  <= S_HSCAN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_TRIM_SEL: begin
          if (hres.lru_r) begin
            h_rd_idx_q <= h_lru;
            ret_q      <= S_TRIM_DROP;
            state_q    <= S_HRD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_TRIM_DROP: begin
          hvalid_q[h_rd_idx_q] <= 1'b0;
          occ_h_q              <= occ_h_q - HOCC_W'(hw_q);
          state_q              <= S_TRIM;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit_q;
            out_where_q <= res_where_q;
            out_adm_q   <= res_adm_q;
            out_rem_q   <= res_rem_q;
            out_ek_q    <= res_ek_q;
            out_sr_q    <= sr_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign hit_where_o     = out_where_q;
  assign admitted_o      = out_adm_q;
  assign removed_o       = out_rem_q;
  assign evicted_key_o   = out_ek_q;
  assign sr_target_now_o = out_sr_q;

  // sr target never drops to zero and r target never exceeds total capacity
  a_r_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sr_q != '0) && (r_q <= tc_q))
    else $error("sr or r target out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted word not taken into the sequencer");

  a_cache_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cvalid_q == '0) |-> (occ_r_q == '0 && occ_sr_q == '0))
    else $error("cache occupancy nonzero with no valid entries");

  a_hist_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hvalid_q == '0) |-> (occ_h_q == '0))
    else $error("history occupancy nonzero with no valid entries");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the scan-resistant LRU replacement engine: a directed opener, then
// random request words under several capacity settings, with every result
// word compared to an in-bench model of the R, SR and history lists.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srlru_pkg::*;

  localparam int NSLOT = 256;

  typedef struct {
    bit          hit;
    bit [1:0]    where_;
    bit          admitted;
    bit          removed;
    bit [31:0]   ev_key;
    bit [15:0]   sr_now;
  } outcome_t;

  typedef struct {
    bit              valid;
    bit              lst;
    bit              is_new;
    bit              demoted;
    bit [31:0]       key;
    longint unsigned weight;
  } cslot_t;

  typedef struct {
    bit              valid;
    bit              is_new;
    bit [31:0]       key;
    longint unsigned weight;
  } hslot_t;

  // list model and queue of predicted result words
  class srlru_tracker;
    cslot_t          cslot[NSLOT];
    longint unsigned cstamp[NSLOT];
    hslot_t          hslot[NSLOT];
    longint unsigned hstamp[NSLOT];
    int unsigned     new_cnt, dem_cnt;
    bit [15:0]       sr_tgt, r_tgt, cap;
    bit [1:0]        meta;
    longint unsigned occ[3];
    longint unsigned clock_stamp;
    outcome_t        pending_q[$];
    int              errors;

    function new();
      cap = CAP_RESET;
      sr_tgt = HALF_RESET;
      r_tgt = HALF_RESET;
    endfunction

    function void write_reg(bit [1:0] idx, bit [15:0] data);
      if (idx == CFG_TOTAL_CAP) begin
        cap = data;
        r_tgt = cap >> 1;
        sr_tgt = (r_tgt != 0) ? r_tgt : 16'd1;
      end else if (idx == CFG_META) begin
        meta = data[1:0];
      end
    endfunction

    function longint unsigned next_stamp();
      clock_stamp++;
      return clock_stamp;
    endfunction

    function void set_sr(longint unsigned v);
      if (v > cap) v = cap;
      if (v < 1) v = 1;
      sr_tgt = v[15:0];
      r_tgt = (cap >= sr_tgt) ? cap - sr_tgt : 16'd0;
    endfunction

    function int cfind(bit [31:0] key);
      for (int i = 0; i < NSLOT; i++) if (cslot[i].valid && cslot[i].key == key) return i;
      return -1;
    endfunction

    function int cfree();
      for (int i = 0; i < NSLOT; i++) if (!cslot[i].valid) return i;
      return -1;
    endfunction

    function int clru(bit lst);
      int b;
      b = -1;
      for (int i = 0; i < NSLOT; i++)
        if (cslot[i].valid && cslot[i].lst == lst && (b < 0 || cstamp[i] < cstamp[b])) b = i;
      return b;
    endfunction

    function int hfind(bit [31:0] key);
      for (int i = 0; i < NSLOT; i++) if (hslot[i].valid && hslot[i].key == key) return i;
      return -1;
    endfunction

    function int hlru();
      int b;
      b = -1;
      for (int i = 0; i < NSLOT; i++)
        if (hslot[i].valid && (b < 0 || hstamp[i] < hstamp[b])) b = i;
      return b;
    endfunction

    function void hdrop(int i);
      hslot[i].valid = 0;
      occ[2] -= hslot[i].weight;
    endfunction

    function void htrim();
      int j;
      while (occ[2] >= cap) begin
        j = hlru();
        if (j < 0) break;
        hdrop(j);
      end
    endfunction

    function void hpush(bit [31:0] key, longint unsigned w, bit is_new);
      int s;
      s = -1;
      for (int i = 0; i < NSLOT; i++) if (!hslot[i].valid) begin s = i; break; end
      if (s < 0) begin
        s = hlru();
        hdrop(s);
      end
      hslot[s] = '{1'b1, is_new, key, w};
      hstamp[s] = next_stamp();
      occ[2] += w;
    endfunction

    function void to_history(int i);
      hpush(cslot[i].key, cslot[i].weight, cslot[i].is_new);
      if (cslot[i].is_new && new_cnt != 32'hffff_ffff) new_cnt++;
      if (cslot[i].demoted && dem_cnt != 0) dem_cnt--;
      occ[cslot[i].lst] -= cslot[i].weight;
      cslot[i].valid = 0;
    endfunction

    function void demote(int i);
      occ[LIST_R] -= cslot[i].weight;
      occ[LIST_SR] += cslot[i].weight;
      cslot[i].lst = LIST_SR;
      cslot[i].is_new = 0;
      if (!cslot[i].demoted) begin
        if (dem_cnt != 32'hffff_ffff) dem_cnt++;
        cslot[i].demoted = 1;
      end
      cstamp[i] = next_stamp();
    endfunction

    function void place(int s, bit lst, bit [31:0] key, longint unsigned w, bit is_new);
      cslot[s] = '{1'b1, lst, is_new, 1'b0, key, w};
      cstamp[s] = next_stamp();
      occ[lst] += w;
    endfunction

    function void note_request(opcode_e op, bit [31:0] key, bit [7:0] size);
      outcome_t        o;
      longint unsigned w, q, tot, lim, ns;
      int              ci, hi, j;
      bit              fits, was;
      o = '{default: 0};
      w = size + meta;
      if (op == OP_GET) begin
        ci = cfind(key);
        if (ci >= 0) begin
          o.hit = 1;
          if (cslot[ci].lst == LIST_R) begin
            o.where_ = WHERE_R;
            cstamp[ci] = next_stamp();
          end else begin
            was = cslot[ci].demoted;
            o.where_ = WHERE_SR;
            occ[LIST_SR] -= cslot[ci].weight;
            place(ci, LIST_R, key, cslot[ci].weight, 0);
            while (occ[LIST_R] > r_tgt) begin
              j = clru(LIST_R);
              if (j < 0) break;
              demote(j);
            end
            if (was) begin
              q = (dem_cnt != 0) ? new_cnt / dem_cnt : 0;
              set_sr(sr_tgt > q + 1 ? sr_tgt - q - 1 : 1);
              if (dem_cnt != 0) dem_cnt--;
            end
          end
        end else begin
          hi = hfind(key);
          if (hi >= 0) begin
            o.where_ = WHERE_HIST;
            fits = w <= r_tgt;
          end else begin
            fits = w <= sr_tgt;
          end
          if (fits && cfree() >= 0) begin
            o.admitted = 1;
            if (hi >= 0) begin
              was = hslot[hi].is_new;
              hdrop(hi);
              while (occ[LIST_R] + w > r_tgt) begin
                j = clru(LIST_R);
                if (j < 0) break;
                demote(j);
              end
              place(cfree(), LIST_R, key, w, 0);
              if (was) begin
                q = (new_cnt != 0) ? dem_cnt / new_cnt : 0;
                tot = occ[LIST_R] + occ[LIST_SR];
                lim = (tot != 0) ? tot - 1 : 0;
                ns = sr_tgt + ((q != 0) ? q : 1);
                set_sr(ns < lim ? ns : lim);
              end
            end else begin
              place(cfree(), LIST_SR, key, w, 1);
            end
            while (occ[LIST_SR] > sr_tgt) begin
              j = clru(LIST_SR);
              if (j < 0) break;
              to_history(j);
            end
            htrim();
          end
        end
      end else if (op == OP_REMOVE) begin
        ci = cfind(key);
        if (ci >= 0) begin
          o.removed = 1;
          to_history(ci);
          htrim();
        end
      end else if (op == OP_EVICT) begin
        j = clru(LIST_SR);
        if (j < 0) j = clru(LIST_R);
        if (j >= 0) begin
          o.removed = 1;
          o.ev_key = cslot[j].key;
          to_history(j);
          htrim();
        end
      end
      o.sr_now = sr_tgt;
      pending_q.push_back(o);
    endfunction

    function void report(string field, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, e, a);
        errors++;
      end
    endfunction

    function void check_result(outcome_t a);
      outcome_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %p", $realtime, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      report("hit", e.hit, a.hit);
      report("hit_where", e.where_, a.where_);
      report("admitted", e.admitted, a.admitted);
      report("removed", e.removed, a.removed);
      report("evicted_key", e.ev_key, a.ev_key);
      report("sr_target_now", e.sr_now, a.sr_now);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [31:0] object_key_i = '0;
  logic [7:0]  object_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [1:0]  hit_where_o;
  logic        admitted_o;
  logic        removed_o;
  logic [31:0] evicted_key_o;
  logic [15:0] sr_target_now_o;

  sr_lru_cache_replacement_top dut (.*);

  srlru_tracker lists = new();
  int           send_idle_pct = 10;
  int           recv_idle_pct = 73;
  bit [31:0]    key_pool[$];

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i)
    if (out_valid_o && out_ready_i)
      lists.check_result('{hit_o, hit_where_o, admitted_o, removed_o, evicted_key_o,
                           sr_target_now_o});

  initial begin
    #150ms;
    $display("testbench: FAIL");
    $finish;
  end

  // valid stays up between back-to-back words; it drops only for a gap or a drain
  task automatic send_word(opcode_e op, bit [31:0] key, bit [7:0] size);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    object_key_i <= key;
    object_size_i <= size;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    lists.note_request(op, key, size);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (lists.pending_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lists.write_reg(idx, data);
  endtask

  task automatic random_word(int max_size);
    int        r;
    bit [7:0]  size;
    r = $urandom_range(99);
    size = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(max_size);
    if (r < 68)      send_word(OP_GET, key_pool[$urandom_range(key_pool.size() - 1)], size);
    else if (r < 82) send_word(OP_REMOVE, key_pool[$urandom_range(key_pool.size() - 1)],
                               $urandom_range(255));
    else if (r < 96) send_word(OP_EVICT, $urandom, $urandom_range(255));
    else             send_word(OP_NOP, $urandom, $urandom_range(255));
  endtask

  initial begin
    bit [15:0] caps[5]  = '{16'd256, 16'd2, 16'd65535, 16'd24, 16'd600};
    bit [1:0]  metas[5] = '{2'd2, 2'd0, 2'd1, 2'd0, 2'd2};
    int        sizes[5] = '{40, 1, 255, 6, 90};
    int        pools[5] = '{48, 6, 400, 16, 64};
    int        done;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed opener on reset settings
    send_word(OP_EVICT, 32'h0, 8'd0);
    send_word(OP_REMOVE, 32'h1234, 8'd0);
    send_word(OP_GET, 32'hffff_ffff, 8'd255);
    send_word(OP_GET, 32'h0, 8'd0);
    send_word(OP_GET, 32'h0, 8'd0);
    send_word(OP_GET, 32'h0, 8'd0);
    send_word(OP_GET, 32'hffff_ffff, 8'd100);
    send_word(OP_GET, 32'h5555_aaaa, 8'd60);
    send_word(OP_EVICT, 32'h0, 8'd0);
    send_word(OP_GET, 32'hffff_ffff, 8'd100);
    send_word(OP_GET, 32'h5555_aaaa, 8'd60);
    send_word(OP_GET, 32'haaaa_5555, 8'd127);
    send_word(OP_GET, 32'h5555_aaaa, 8'd60);
    send_word(OP_NOP, 32'hffff_ffff, 8'd255);
    drain();
    send_word(OP_REMOVE, 32'h0, 8'd0);
    send_word(OP_REMOVE, 32'h0, 8'd0);
    send_word(OP_EVICT, 32'h0, 8'd0);
    send_word(OP_EVICT, 32'h0, 8'd0);
    send_word(OP_EVICT, 32'h0, 8'd0);
    send_word(OP_EVICT, 32'h0, 8'd0);
    drain();

    done = 0;
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_TOTAL_CAP, caps[p]);
      write_reg(CFG_META, metas[p]);
      key_pool.delete();
      key_pool.push_back(32'h0);
      key_pool.push_back(32'hffff_ffff);
      for (int k = 0; k < pools[p]; k++) key_pool.push_back($urandom);
      for (int n = 0; n < 160; n++) begin
        if (done < 270) begin
          send_idle_pct = 10;
          recv_idle_pct = 73;
        end else if (done < 540) begin
          send_idle_pct = 73;
          recv_idle_pct = 10;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        random_word(sizes[p]);
        done++;
      end
      drain();
    end

    wait (lists.pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (lists.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
